@@ rtl/btda_pkg.sv @@
package btda_pkg;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned CHAR_W       = 6;
  localparam int unsigned VALUE_BITS_D = 32;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [3:0]        BCD_MAX    = 4'd9;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_OUT
  } state_e;

endpackage

@@ rtl/binary_to_decimal_ascii.sv @@
// operation: the input value is shifted bit-serially through the row of decimal digit cells,
//   then the digits are shifted out most significant first, skipping up to DIGITS-1 leading
//   zeros; each emitted digit is registered on the output and waits while out_stall_i holds it
//   a new value is accepted only when idle, after the last digit of the previous one is out
// reset: asynchronous, active low; clears the control state and the output valid
module binary_to_decimal_ascii
  import btda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_D
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] digit_char_o,
  output logic              last_digit_o
);

  // decimal digits of 2^VALUE_BITS - 1
  localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned CNT_MAX = (VALUE_BITS > DIGITS) ? VALUE_BITS : DIGITS;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  state_e state_q, state_d;
  cell_op_e cell_op;

  logic [VALUE_BITS-1:0] value_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  seen_q;
  logic                  out_valid_q;
  logic [3:0]            out_digit_q;
  logic                  out_last_q;

  logic [DIGITS-1:0][3:0] digit;
  logic [DIGITS:0]        carry;

  logic in_acc, out_free, last_cnt, top_zero, skip, advance, emit, conv, load;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_cnt = (cnt_q == CNT_W'(1));
  assign top_zero = (digit[DIGITS-1] == 4'd0);
  assign skip     = top_zero && !seen_q && !last_cnt;
  assign carry[0] = value_q[VALUE_BITS-1];

  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    logic [3:0] lower;
    if (g == 0) begin : g_first
      assign lower = 4'd0;
    end else begin : g_rest
      assign lower = digit[g-1];
    end
    btda_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .bit_i   (carry[g]),
      .digit_i (lower),
      .carry_o (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CONV;
      end
      S_CONV: begin
        if (last_cnt) state_d = S_OUT;
      end
      S_OUT: begin
        if (advance && last_cnt) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cell_op    = CELL_HOLD;
    in_stall_o = 1'b1;
    advance    = 1'b0;
    emit       = 1'b0;
    conv       = 1'b0;
    load       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          cell_op = CELL_CLEAR;
          load    = 1'b1;
        end
      end
      S_CONV: begin
        cell_op = CELL_DABBLE;
        conv    = 1'b1;
      end
      S_OUT: begin
        if (skip || out_free) begin
          cell_op = CELL_SHIFT;
          advance = 1'b1;
          emit    = !skip;
        end
      end
      default: cell_op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q  <= CNT_W'(VALUE_BITS);
        seen_q <= 1'b0;
      end else if (conv) begin
        cnt_q <= last_cnt ? CNT_W'(DIGITS) : cnt_q - CNT_W'(1);
      end else if (advance) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (emit) begin
        seen_q      <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= value_i[VALUE_BITS-1:0];
    end else if (conv) begin
      value_q <= {value_q[VALUE_BITS-2:0], 1'b0};
    end
    if (emit) begin
      out_digit_q <= digit[DIGITS-1];
      out_last_q  <= last_cnt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = ASCII_ZERO + {2'b00, out_digit_q};
  assign last_digit_o = out_last_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_CONV)
    else $error("accepted beat did not start conversion");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CONV |-> !carry[DIGITS])
    else $error("carry out of the top digit cell");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && advance && last_cnt) |=> state_q == S_IDLE && out_valid_o
      && last_digit_o)
    else $error("final digit not flagged on the output");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> cnt_q != '0)
    else $error("digit count ran out while shifting");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_digit_q <= BCD_MAX)
    else $error("output digit out of decimal range");

endmodule

@@ rtl/btda_cell.sv @@
module btda_cell
  import btda_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_op_e   op_i,
  input  logic       bit_i,
  input  logic [3:0] digit_i,
  output logic       carry_o,
  output logic [3:0] digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // add three before the shift when the digit would overflow past nine
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    case (op_i)
      CELL_CLEAR:  digit_d = 4'd0;
      CELL_DABBLE: digit_d = {adj[2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  a_digit_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= BCD_MAX)
    else $error("cell holds a non-decimal digit");

endmodule
